### design/sotc_pkg.sv
`default_nettype none

package sotc_pkg;

   // Field widths fixed by the interface.
   localparam int OFFSET_BITS   = 32;
   localparam int MAG_BITS      = 32;
   localparam int SIZE_BITS     = 16;
   localparam int OUT_BITS      = 16;
   localparam int BIAS_BITS     = 48;
   localparam int MAX_DIMS      = 4;

   // Signed offset plus unsigned bias, and its magnitude.
   localparam int SUM_BITS      = BIAS_BITS + 2;
   localparam int DIVD_BITS     = BIAS_BITS + 1;
   localparam int PAD_BITS      = DIVD_BITS - MAG_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIVD_BITS);
   localparam int VAL_BITS      = DIVD_BITS + 2;

   // Configuration register map.
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRIDE_BASE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_BASE   = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_DIV,
      ST_POST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture_sum;
      logic setup_step;
      logic load_first;
      logic load_next;
      logic div_step;
      logic post;
      logic push;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### design/strided_offset_to_coordinates.sv
// Items are handled one at a time, since one shared restoring divider serves every dimension:
// 49 quotient bits for the first dimension, 32 for each other; req_stall is high until the
// result is pushed.
// After each register write, set-up steps through the dimensions while req_stall is high.
// Synchronous active-high reset: strides and sizes 1, identity order, zero bias, no result.
`default_nettype none

module strided_offset_to_coordinates
   import sotc_pkg::*;
#(
   parameter int NUM_DIMS   = 4,
   parameter int COORD_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [OFFSET_BITS-1:0]   req_pixel_offset,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [OUT_BITS-1:0]      rsp_coord_dim0,
   output      logic [OUT_BITS-1:0]      rsp_coord_dim1,
   output      logic [OUT_BITS-1:0]      rsp_coord_dim2,
   output      logic [OUT_BITS-1:0]      rsp_coord_dim3,
   input  wire logic                     csr_write_en,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_write_data
);

   ctrl_cmd_type                  cmd;
   logic [$clog2(NUM_DIMS+1)-1:0] cmd_idx;

   sotc_ctrl #(
      .NUM_DIMS (NUM_DIMS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .cmd          (cmd),
      .cmd_idx      (cmd_idx)
   );

   sotc_datapath #(
      .NUM_DIMS   (NUM_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_pixel_offset (req_pixel_offset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .cmd_idx          (cmd_idx),
      .rsp_coord_dim0   (rsp_coord_dim0),
      .rsp_coord_dim1   (rsp_coord_dim1),
      .rsp_coord_dim2   (rsp_coord_dim2),
      .rsp_coord_dim3   (rsp_coord_dim3)
   );

endmodule

`default_nettype wire

### design/sotc_divider.sv
`default_nettype none

module sotc_divider
   import sotc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic [DIVD_BITS-1:0] load_value,
   input  wire logic [MAG_BITS-1:0]  load_mag,
   input  wire logic                 step,
   output      logic [DIVD_BITS-1:0] quotient,
   output      logic [MAG_BITS-1:0]  remainder
);

   logic [DIVD_BITS-1:0] dvd_ff, dvd_in;
   logic [MAG_BITS-1:0]  rem_ff, rem_in;
   logic [MAG_BITS-1:0]  mag_ff, mag_in;
   logic [MAG_BITS:0]    trial;
   logic [MAG_BITS:0]    diff;
   logic                 fits;

   // Restoring division, one quotient bit per step. The quotient bits shift
   // into the bottom of the dividend register as the dividend leaves the top.
   always_comb begin
      trial  = {rem_ff, dvd_ff[DIVD_BITS-1]};
      diff   = trial - {1'b0, mag_ff};
      fits   = (trial >= {1'b0, mag_ff});
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      mag_in = mag_ff;
      if (load) begin
         dvd_in = load_value;
         rem_in = '0;
         mag_in = load_mag;
      end else if (step) begin
         dvd_in = {dvd_ff[DIVD_BITS-2:0], fits};
         rem_in = fits ? diff[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      mag_ff <= mag_in;
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### design/sotc_datapath.sv
`default_nettype none

module sotc_datapath
   import sotc_pkg::*;
#(
   parameter int NUM_DIMS   = 4,
   parameter int COORD_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [OFFSET_BITS-1:0]           req_pixel_offset,
   input  wire logic                             csr_write_en,
   input  wire logic [CSR_IDX_BITS-1:0]          csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]         csr_write_data,
   input  wire ctrl_cmd_type                     cmd,
   input  wire logic [$clog2(NUM_DIMS+1)-1:0]    cmd_idx,
   output      logic [OUT_BITS-1:0]              rsp_coord_dim0,
   output      logic [OUT_BITS-1:0]              rsp_coord_dim1,
   output      logic [OUT_BITS-1:0]              rsp_coord_dim2,
   output      logic [OUT_BITS-1:0]              rsp_coord_dim3
);

   localparam int DIM_BITS = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
   localparam int CNT_BITS = $clog2(NUM_DIMS + 1);
   localparam logic [VAL_BITS-1:0] COORD_MAX = VAL_BITS'((64'd1 << COORD_BITS) - 64'd1);

   // Configuration registers.
   logic [MAG_BITS-1:0]  stride_ff [NUM_DIMS];
   logic [SIZE_BITS-1:0] size_ff   [NUM_DIMS];

   // Per-dimension values derived from the registers.
   logic                 act_d [NUM_DIMS];
   logic                 rev_d [NUM_DIMS];
   logic [MAG_BITS-1:0]  mag_d [NUM_DIMS];
   logic [SIZE_BITS-1:0] sm1_d [NUM_DIMS];

   // Set-up state.
   logic [DIM_BITS-1:0]  order_ff [NUM_DIMS];
   logic [BIAS_BITS-1:0] bias_ff, bias_in;
   logic [BIAS_BITS-1:0] prod_ff, prod_in;
   logic [DIM_BITS-1:0]  k;
   logic                 k_valid;
   logic                 k_act;
   logic                 k_rev;
   logic [MAG_BITS-1:0]  k_mag;
   logic [SIZE_BITS-1:0] k_sm1;
   logic [BIAS_BITS-1:0] k_prod;
   logic [DIM_BITS-1:0]  rank;

   // Per-item state.
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [SUM_BITS-1:0]  sum_abs;
   logic                 sign_ff, sign_in;
   logic [DIM_BITS-1:0]  cur_dim_ff, cur_dim_in;
   logic [DIM_BITS-1:0]  load_dim;
   logic                 div_load;
   logic [DIVD_BITS-1:0] div_value;
   logic [DIVD_BITS-1:0] quotient;
   logic [MAG_BITS-1:0]  remainder;
   logic [VAL_BITS-1:0]  q_ext;
   logic [VAL_BITS-1:0]  sm1_ext;
   logic [VAL_BITS-1:0]  value;
   logic [OUT_BITS-1:0]  coord_val;
   logic [OUT_BITS-1:0]  coord_ff  [NUM_DIMS];
   logic [OUT_BITS-1:0]  coord_all [MAX_DIMS];
   logic [OUT_BITS-1:0]  rsp_ff    [MAX_DIMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            stride_ff[d] <= MAG_BITS'(1);
            size_ff[d]   <= SIZE_BITS'(1);
         end
      end else if (csr_write_en) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (csr_index == CSR_STRIDE_BASE + CSR_IDX_BITS'(d)) begin
               stride_ff[d] <= csr_write_data[MAG_BITS-1:0];
            end
            if (csr_index == CSR_SIZE_BASE + CSR_IDX_BITS'(d)) begin
               size_ff[d] <= csr_write_data[SIZE_BITS-1:0];
            end
         end
      end
   end

   // A dimension with a negative stride is walked mirrored; the most negative
   // stride negates to itself, which is exactly its magnitude as unsigned.
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         act_d[d] = (size_ff[d] != SIZE_BITS'(1)) && (stride_ff[d] != '0);
         rev_d[d] = act_d[d] && stride_ff[d][MAG_BITS-1];
         if (!act_d[d]) begin
            mag_d[d] = MAG_BITS'(1);
         end else if (stride_ff[d][MAG_BITS-1]) begin
            mag_d[d] = '0 - stride_ff[d];
         end else begin
            mag_d[d] = stride_ff[d];
         end
         sm1_d[d] = size_ff[d] - SIZE_BITS'(1);
      end
   end

   // Set-up handles one dimension a cycle: its rank in the processing order
   // and its share of the mirror bias.
   always_comb begin
      k       = cmd_idx[DIM_BITS-1:0];
      k_valid = (cmd_idx < CNT_BITS'(NUM_DIMS));
      k_act   = act_d[k];
      k_rev   = rev_d[k];
      k_mag   = mag_d[k];
      k_sm1   = sm1_d[k];
      k_prod  = BIAS_BITS'(k_mag) * BIAS_BITS'(k_sm1);
      rank    = '0;
      for (int j = 0; j < NUM_DIMS; j++) begin
         if (DIM_BITS'(j) != k) begin
            if ((act_d[j] && !k_act) ||
                (act_d[j] && k_act && ((mag_d[j] > k_mag) ||
                                       ((mag_d[j] == k_mag) && (DIM_BITS'(j) < k)))) ||
                (!act_d[j] && !k_act && (DIM_BITS'(j) < k))) begin
               rank = rank + DIM_BITS'(1);
            end
         end
      end
      bias_in = bias_ff;
      prod_in = prod_ff;
      if (csr_write_en) begin
         bias_in = '0;
         prod_in = '0;
      end else if (cmd.setup_step) begin
         bias_in = bias_ff + prod_ff;
         prod_in = (k_valid && k_rev) ? k_prod : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         prod_ff <= '0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            order_ff[d] <= DIM_BITS'(d);
         end
      end else begin
         bias_ff <= bias_in;
         prod_ff <= prod_in;
         if (!csr_write_en && cmd.setup_step && k_valid) begin
            order_ff[rank] <= k;
         end
      end
   end

   // Item path. The sign of the biased offset is held aside all the way
   // down, so the divider works on magnitudes and the sign is applied at the end.
   always_comb begin
      sum_in = sum_ff;
      if (cmd.capture_sum) begin
         sum_in = {{(SUM_BITS-OFFSET_BITS){req_pixel_offset[OFFSET_BITS-1]}}, req_pixel_offset}
                  + {{(SUM_BITS-BIAS_BITS){1'b0}}, bias_ff};
      end
      sum_abs    = sum_ff[SUM_BITS-1] ? ('0 - sum_ff) : sum_ff;
      load_dim   = order_ff[cmd_idx[DIM_BITS-1:0]];
      div_load   = cmd.load_first || cmd.load_next;
      div_value  = cmd.load_first ? sum_abs[DIVD_BITS-1:0]
                                  : {remainder, {PAD_BITS{1'b0}}};
      sign_in    = cmd.load_first ? sum_ff[SUM_BITS-1] : sign_ff;
      cur_dim_in = div_load ? load_dim : cur_dim_ff;
   end

   sotc_divider u_divider (
      .clock      (clock),
      .load       (div_load),
      .load_value (div_value),
      .load_mag   (mag_d[load_dim]),
      .step       (cmd.div_step),
      .quotient   (quotient),
      .remainder  (remainder)
   );

   // A mirrored coordinate is (size - 1) minus the signed quotient; the
   // result is clamped to the coordinate range.
   always_comb begin
      q_ext   = {{(VAL_BITS-DIVD_BITS){1'b0}}, quotient};
      sm1_ext = {{(VAL_BITS-SIZE_BITS){1'b0}}, sm1_d[cur_dim_ff]};
      if (rev_d[cur_dim_ff]) begin
         value = sign_ff ? (sm1_ext + q_ext) : (sm1_ext - q_ext);
      end else begin
         value = sign_ff ? '0 : q_ext;
      end
      if (value[VAL_BITS-1]) begin
         coord_val = '0;
      end else if (value > COORD_MAX) begin
         coord_val = COORD_MAX[OUT_BITS-1:0];
      end else begin
         coord_val = value[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      sign_ff    <= sign_in;
      cur_dim_ff <= cur_dim_in;
      if (cmd.post) begin
         coord_ff[cur_dim_ff] <= coord_val;
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         coord_all[d] = '0;
      end
      for (int d = 0; d < NUM_DIMS; d++) begin
         coord_all[d] = coord_ff[d];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            rsp_ff[d] <= coord_all[d];
         end
      end
   end

   assign rsp_coord_dim0 = rsp_ff[0];
   assign rsp_coord_dim1 = rsp_ff[1];
   assign rsp_coord_dim2 = rsp_ff[2];
   assign rsp_coord_dim3 = rsp_ff[3];

endmodule

`default_nettype wire

### design/sotc_ctrl.sv
`default_nettype none

module sotc_ctrl
   import sotc_pkg::*;
#(
   parameter int NUM_DIMS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          csr_write_en,
   output      ctrl_cmd_type                  cmd,
   output      logic [$clog2(NUM_DIMS+1)-1:0] cmd_idx
);

   localparam int CNT_BITS = $clog2(NUM_DIMS + 1);

   state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIV_CNT_BITS-1:0]  bit_ff, bit_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      cmd          = '0;
      cmd_idx      = cnt_ff;
      req_stall    = (state_ff != ST_IDLE) || csr_write_en;
      // The result register stays full until its transfer completes.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write_en) begin
               state_in = ST_SETUP;
               cnt_in   = '0;
            end else if (req_valid) begin
               cmd.capture_sum = 1'b1;
               cnt_in          = '0;
               state_in        = ST_LOAD;
            end
         end
         ST_SETUP: begin
            cmd.setup_step = 1'b1;
            if (csr_write_en) begin
               cnt_in = '0;
            end else if (cnt_ff == CNT_BITS'(NUM_DIMS)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_LOAD: begin
            cmd.load_first = 1'b1;
            bit_in         = DIV_CNT_BITS'(DIVD_BITS - 1);
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_POST;
            end else begin
               bit_in = bit_ff - DIV_CNT_BITS'(1);
            end
         end
         ST_POST: begin
            cmd.post = 1'b1;
            cmd_idx  = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(NUM_DIMS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cmd.load_next = 1'b1;
               cnt_in        = cnt_ff + CNT_BITS'(1);
               bit_in        = DIV_CNT_BITS'(MAG_BITS - 1);
               state_in      = ST_DIV;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not start processing");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented without a finished item");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=>
      (state_ff == ST_DONE && rsp_valid_ff))
      else $error("finished item dropped while the result register was full");

   a_write_restarts_setup: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && (state_ff == ST_IDLE || state_ff == ST_SETUP)) |=>
      (state_ff == ST_SETUP && cnt_ff == '0))
      else $error("register write did not restart set-up");

endmodule

`default_nettype wire
